>>> sv/mspp_pkg.sv
// mspp_pkg: shared constants, register codes, status struct and the
// elaboration-time functions that build the sRGB decode and alpha tables
// no dependencies
package mspp_pkg;

    // default fraction width of the linear values
    localparam int FRACTION_BITS_DEF = 15;

    // fixed field widths
    localparam int PIX_W      = 8;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    // depth of the queue between classifier and picker, a power of two
    localparam int QUEUE_DEPTH = 2;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DARK_THR   = 8'd0,
        REG_BRIGHT_THR = 8'd1
    } cfg_reg_t;

    // picker status seen by the top level
    typedef struct packed {
        logic pop;       // a classified word leaves the queue
        logic pop_last;  // that word closes the image
    } back_stat_t;

    // Q30 multiply with truncation
    function automatic longint unsigned qmul(input longint unsigned a,
                                             input longint unsigned b);
        return (a * b) >> 30;
    endfunction

    function automatic longint unsigned fifth_power(input longint unsigned y);
        longint unsigned y2;
        longint unsigned y4;
        y2 = qmul(y, y);
        y4 = qmul(y2, y2);
        return qmul(y4, y);
    endfunction

    // sRGB code to linear, rounded half up to fb fraction bits
    function automatic longint unsigned srgb_entry(input int code, input int fb);
        longint unsigned c;
        longint unsigned r;
        longint unsigned t;
        longint unsigned t2;
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        longint unsigned q30;
        q30 = 64'd1 << 30;
        c   = 64'(code);
        if (c <= 64'd10) begin
            r = (c * 64'd25 * q30) / 64'd82365;
        end else begin
            t  = ((64'd1000 * c + 64'd14025) * q30) / 64'd269025;
            t2 = qmul(t, t);
            lo = 64'd0;
            hi = q30;
            // largest y whose fifth power stays within t squared
            while (lo < hi) begin
                mid = (lo + hi + 64'd1) >> 1;
                if (fifth_power(mid) <= t2)
                    lo = mid;
                else
                    hi = mid - 64'd1;
            end
            r = qmul(t2, lo);
        end
        return (r + (64'd1 << (29 - fb))) >> (30 - fb);
    endfunction

    // alpha code to A/255 rounded to nearest
    function automatic longint unsigned alpha_entry(input int code, input int fb);
        longint unsigned a;
        a = 64'(code);
        return (a * (64'd2 << fb) + 64'd255) / 64'd510;
    endfunction

endpackage

>>> sv/most_saturated_pixel_picker_top.sv
// most_saturated_pixel_picker_top: classifier, queue and picker joined up
// depends on mspp_pkg, mspp_front, mspp_fifo, mspp_back
//
//  channel  direction  ports                          word
//  -------  ---------  -----------------------------  -------------------------------
//  cfg      in         cfg_valid/ready/index/data     threshold register write
//  s_       in         s_tvalid/tready/tdata/tlast    one sRGB pixel, tlast ends image
//  m_       out        m_tvalid/tready/tdata/tuser    chosen linear colour, one per image
//
// one pixel word accepted every cycle unless the classifier register is held up;
// decode tables and min/max feed the classifier register, the single cross-multiply
// compare feeds the picker registers; the closing pixel passes the classifier register,
// the queue and the result register; the tables are constant logic and need no fill
// a stalled result holds only closing words back; the two-entry queue and
// the classifier register keep taking pixels until full
module most_saturated_pixel_picker_top import mspp_pkg::*; #(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    // configuration
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data,
    // pixel stream
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [4*PIX_W-1:0]      s_tdata,   // red, green, blue, alpha
    input  logic                    s_tlast,   // last_pixel
    // result stream
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [((4*(FRACTION_BITS+1)+7)/8)*8-1:0] m_tdata,
                                    // red_linear, green_linear, blue_linear, alpha_linear
    output logic [0:0]              m_tuser    // found_colour
);

    localparam int LW      = FRACTION_BITS + 1;
    localparam int ITEM_W  = 6 * LW + 2;
    localparam int TDATA_W = ((4 * LW + 7) / 8) * 8;
    localparam logic [LW-1:0] ONE = {1'b1, {FRACTION_BITS{1'b0}}};

    logic              fr_valid, fr_ready;
    logic [ITEM_W-1:0] fr_item;
    logic              q_valid, q_ready;
    logic [ITEM_W-1:0] q_item;
    logic [4*LW-1:0]   bk_data;
    logic              bk_found;
    back_stat_t        bk_stat;

    assign cfg_ready = 1'b1;

    // classifier
    mspp_front #(.FRACTION_BITS(FRACTION_BITS)) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_valid   (s_tvalid),
        .s_ready   (s_tready),
        .s_pix     (s_tdata),
        .s_last    (s_tlast),
        .o_valid   (fr_valid),
        .o_ready   (fr_ready),
        .o_item    (fr_item)
    );

    // queue
    mspp_fifo #(.WIDTH(ITEM_W), .DEPTH(QUEUE_DEPTH)) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fr_valid),
        .in_ready  (fr_ready),
        .in_data   (fr_item),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_data  (q_item)
    );

    // picker
    mspp_back #(.FRACTION_BITS(FRACTION_BITS)) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .i_valid (q_valid),
        .i_ready (q_ready),
        .i_item  (q_item),
        .m_valid (m_tvalid),
        .m_ready (m_tready),
        .m_data  (bk_data),
        .m_found (bk_found),
        .stat    (bk_stat)
    );

    assign m_tdata    = TDATA_W'(bk_data);
    assign m_tuser[0] = bk_found;

    // no qualifier means opaque white
    a_white_fallback: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !bk_found) |->
            (bk_data[LW-1:0] == ONE) && (bk_data[2*LW-1:LW] == ONE) &&
            (bk_data[3*LW-1:2*LW] == ONE) && (bk_data[4*LW-1:3*LW] == ONE))
        else $error("white fallback carries a colour");

    // a chosen pixel was never transparent
    a_found_opaque: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && bk_found) |-> (bk_data[4*LW-1:3*LW] != '0))
        else $error("chosen pixel has zero alpha");

    // a result word only follows a closing pixel leaving the queue
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(bk_stat.pop_last))
        else $error("result word without closing pixel");

    // the picker never takes from an empty queue
    a_pop_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        bk_stat.pop |-> q_valid)
        else $error("picker popped an empty queue");

endmodule

>>> sv/mspp_front.sv
// mspp_front: threshold registers, sRGB decode tables, min/max and the
// qualify test, ending in one output register towards the queue
// depends on mspp_pkg
module mspp_front import mspp_pkg::*; #(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration writes
    input  logic                          cfg_valid,
    input  logic [CFG_IDX_W-1:0]          cfg_index,
    input  logic [CFG_DATA_W-1:0]         cfg_data,
    // pixel words
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [4*PIX_W-1:0]            s_pix,   // red, green, blue, alpha
    input  logic                          s_last,
    // classified words
    output logic                          o_valid,
    input  logic                          o_ready,
    output logic [6*(FRACTION_BITS+1)+1:0] o_item
);

    localparam int LW     = FRACTION_BITS + 1;
    localparam int THR_W  = (LW > CFG_DATA_W) ? LW : CFG_DATA_W;
    localparam int ITEM_W = 6 * LW + 2;
    localparam int NCODES = 1 << PIX_W;

    localparam logic [THR_W-1:0] DARK_RST   = THR_W'((64'd3 << FRACTION_BITS) / 64'd20);
    localparam logic [THR_W-1:0] BRIGHT_RST = THR_W'((64'd9 << FRACTION_BITS) / 64'd10);

    logic [THR_W-1:0]  dark_thr_reg, dark_thr_next;
    logic [THR_W-1:0]  bright_thr_reg, bright_thr_next;
    logic              o_valid_reg, o_valid_next;
    logic [ITEM_W-1:0] o_item_reg, o_item_next;

    logic [LW-1:0] lin_rom   [NCODES];
    logic [LW-1:0] alpha_rom [NCODES];

    logic [PIX_W-1:0] red, green, blue, alpha;
    logic [LW-1:0]    lin_r, lin_g, lin_b, lin_a;
    logic [LW-1:0]    mx, mn, spread, peak;
    logic             qual;
    logic             take;

    // constant decode tables, worked out at elaboration
    for (genvar c = 0; c < NCODES; c++) begin : g_rom
        localparam logic [LW-1:0] LIN_V   = LW'(srgb_entry(c, FRACTION_BITS));
        localparam logic [LW-1:0] ALPHA_V = LW'(alpha_entry(c, FRACTION_BITS));
        assign lin_rom[c]   = LIN_V;
        assign alpha_rom[c] = ALPHA_V;
    end

    // threshold registers
    always_comb begin
        dark_thr_next   = dark_thr_reg;
        bright_thr_next = bright_thr_reg;
        if (cfg_valid) begin
            case (cfg_index)
                REG_DARK_THR:   dark_thr_next   = THR_W'(cfg_data);
                REG_BRIGHT_THR: bright_thr_next = THR_W'(cfg_data);
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dark_thr_reg   <= DARK_RST;
            bright_thr_reg <= BRIGHT_RST;
        end else begin
            dark_thr_reg   <= dark_thr_next;
            bright_thr_reg <= bright_thr_next;
        end
    end

    // decode and classify
    always_comb begin
        red   = s_pix[PIX_W-1:0];
        green = s_pix[2*PIX_W-1:PIX_W];
        blue  = s_pix[3*PIX_W-1:2*PIX_W];
        alpha = s_pix[4*PIX_W-1:3*PIX_W];
        lin_r = lin_rom[red];
        lin_g = lin_rom[green];
        lin_b = lin_rom[blue];
        lin_a = alpha_rom[alpha];

        mx = lin_r;
        mn = lin_r;
        if (lin_g > mx) mx = lin_g;
        if (lin_b > mx) mx = lin_b;
        if (lin_g < mn) mn = lin_g;
        if (lin_b < mn) mn = lin_b;

        spread = mx - mn;
        // black peak counts as one so its saturation reads as zero
        peak   = (mx == '0) ? LW'(1) : mx;
        qual   = (alpha != '0) &&
                 !((THR_W'(mx) < dark_thr_reg) || (THR_W'(mn) > bright_thr_reg));
    end

    // output register towards the queue
    assign s_ready = !o_valid_reg || o_ready;
    assign take    = s_valid && s_ready;

    always_comb begin
        o_valid_next = o_valid_reg && !o_ready;
        o_item_next  = o_item_reg;
        if (take) begin
            o_valid_next = 1'b1;
            o_item_next  = {s_last, qual, peak, spread, lin_a, lin_b, lin_g, lin_r};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            o_valid_reg <= 1'b0;
        end else begin
            o_valid_reg <= o_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        o_item_reg <= o_item_next;
    end

    assign o_valid = o_valid_reg;
    assign o_item  = o_item_reg;

endmodule

>>> sv/mspp_fifo.sv
// mspp_fifo: short register queue between classifier and picker
// depends on mspp_pkg for the default depth
module mspp_fifo import mspp_pkg::*; #(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = AW + 1;

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             push, pop;

    assign in_ready  = (count_reg != CW'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_data  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // pointer and fill count
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        if (pop)  rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        if (push && !pop) count_next = count_reg + CW'(1);
        if (pop && !push) count_next = count_reg - CW'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (push) mem_reg[wr_ptr_reg] <= in_data;
    end

endmodule

>>> sv/mspp_back.sv
// mspp_back: keeps the most saturated qualifying pixel, judges each
// classified word by cross-multiplication and drives the result register
// depends on mspp_pkg
module mspp_back import mspp_pkg::*; #(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // classified words from the queue
    input  logic                            i_valid,
    output logic                            i_ready,
    input  logic [6*(FRACTION_BITS+1)+1:0]  i_item,
    // result words
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [4*(FRACTION_BITS+1)-1:0]  m_data,  // red, green, blue, alpha
    output logic                            m_found,
    output back_stat_t                      stat
);

    localparam int LW = FRACTION_BITS + 1;
    localparam logic [LW-1:0] ONE = {1'b1, {FRACTION_BITS{1'b0}}};

    logic [LW-1:0] best_red_reg,    best_red_next;
    logic [LW-1:0] best_green_reg,  best_green_next;
    logic [LW-1:0] best_blue_reg,   best_blue_next;
    logic [LW-1:0] best_alpha_reg,  best_alpha_next;
    logic [LW-1:0] best_spread_reg, best_spread_next;
    logic [LW-1:0] best_peak_reg,   best_peak_next;
    logic          have_best_reg,   have_best_next;

    logic            m_valid_reg, m_valid_next;
    logic [4*LW-1:0] m_data_reg,  m_data_next;
    logic            m_found_reg, m_found_next;

    logic [LW-1:0]   it_r, it_g, it_b, it_a, it_spread, it_peak;
    logic            it_qual, it_last;
    logic [2*LW-1:0] prod_new, prod_old;
    logic            better, pop;
    logic [LW-1:0]   j_r, j_g, j_b, j_a, j_spread, j_peak;
    logic            j_have;

    // unpack the classified word
    always_comb begin
        it_r      = i_item[LW-1:0];
        it_g      = i_item[2*LW-1:LW];
        it_b      = i_item[3*LW-1:2*LW];
        it_a      = i_item[4*LW-1:3*LW];
        it_spread = i_item[5*LW-1:4*LW];
        it_peak   = i_item[6*LW-1:5*LW];
        it_qual   = i_item[6*LW];
        it_last   = i_item[6*LW+1];
    end

    // a closing word waits until the result register is free
    assign i_ready = !it_last || !m_valid_reg || m_ready;
    assign pop     = i_valid && i_ready;

    // saturation compare by cross-multiplication, strictly greater wins
    always_comb begin
        prod_new = (2*LW)'(it_spread) * (2*LW)'(best_peak_reg);
        prod_old = (2*LW)'(best_spread_reg) * (2*LW)'(it_peak);
        better   = it_qual && (!have_best_reg || (prod_new > prod_old));

        j_r      = better ? it_r      : best_red_reg;
        j_g      = better ? it_g      : best_green_reg;
        j_b      = better ? it_b      : best_blue_reg;
        j_a      = better ? it_a      : best_alpha_reg;
        j_spread = better ? it_spread : best_spread_reg;
        j_peak   = better ? it_peak   : best_peak_reg;
        j_have   = better || have_best_reg;
    end

    // best state and result register
    always_comb begin
        best_red_next    = best_red_reg;
        best_green_next  = best_green_reg;
        best_blue_next   = best_blue_reg;
        best_alpha_next  = best_alpha_reg;
        best_spread_next = best_spread_reg;
        best_peak_next   = best_peak_reg;
        have_best_next   = have_best_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        m_data_next      = m_data_reg;
        m_found_next     = m_found_reg;
        if (pop) begin
            if (it_last) begin
                // emit the judged colour and start a fresh image
                m_valid_next     = 1'b1;
                m_data_next      = {j_a, j_b, j_g, j_r};
                m_found_next     = j_have;
                best_red_next    = ONE;
                best_green_next  = ONE;
                best_blue_next   = ONE;
                best_alpha_next  = ONE;
                best_spread_next = '0;
                best_peak_next   = '0;
                have_best_next   = 1'b0;
            end else begin
                best_red_next    = j_r;
                best_green_next  = j_g;
                best_blue_next   = j_b;
                best_alpha_next  = j_a;
                best_spread_next = j_spread;
                best_peak_next   = j_peak;
                have_best_next   = j_have;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            best_red_reg    <= ONE;
            best_green_reg  <= ONE;
            best_blue_reg   <= ONE;
            best_alpha_reg  <= ONE;
            best_spread_reg <= '0;
            best_peak_reg   <= '0;
            have_best_reg   <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            best_red_reg    <= best_red_next;
            best_green_reg  <= best_green_next;
            best_blue_reg   <= best_blue_next;
            best_alpha_reg  <= best_alpha_next;
            best_spread_reg <= best_spread_next;
            best_peak_reg   <= best_peak_next;
            have_best_reg   <= have_best_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg  <= m_data_next;
        m_found_reg <= m_found_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_data        = m_data_reg;
    assign m_found       = m_found_reg;
    assign stat.pop      = pop;
    assign stat.pop_last = pop && it_last;

endmodule

>>> sim/tb_most_saturated_pixel_picker_top.sv
// tb_most_saturated_pixel_picker_top: self-checking bench for the saturated pixel picker
// depends on mspp_pkg and most_saturated_pixel_picker_top; drives pixel words and
// threshold writes, predicts the chosen colour per image and checks every result word
module tb_most_saturated_pixel_picker_top import mspp_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          LIN_W = FRACTION_BITS_DEF + 1;
    localparam int          MT_W  = ((4 * LIN_W + 7) / 8) * 8;
    localparam logic [15:0] ONE   = 16'd32768;
    localparam logic [15:0] DARK_RST   = 16'd4915;
    localparam logic [15:0] BRIGHT_RST = 16'd29491;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       last;
    } pixel_t;

    typedef struct packed {
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
        logic [15:0] alpha;
        logic        found;
    } colour_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [4*PIX_W-1:0]    s_tdata   = '0;   // red, green, blue, alpha
    logic                  s_tlast   = 1'b0; // last_pixel
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [MT_W-1:0]       m_tdata;          // red_linear, green_linear, blue_linear, alpha_linear
    logic [0:0]            m_tuser;          // found_colour

    // bench state
    pixel_t      pixel_queue[$];
    colour_t     colour_due[$];
    pixel_t      offered_px;
    logic [15:0] lin_lut [256];
    logic [15:0] dark_thr   = DARK_RST;
    logic [15:0] bright_thr = BRIGHT_RST;
    logic [15:0] best_red   = ONE;
    logic [15:0] best_green = ONE;
    logic [15:0] best_blue  = ONE;
    logic [15:0] best_alpha = ONE;
    logic [15:0] best_spread = '0;
    logic [15:0] best_peak   = '0;
    logic        have_best   = 1'b0;
    int          tx_idle_pct = 0;
    int          rx_idle_pct = 0;
    logic        hold_rx     = 1'b0;
    int          accepted_px = 0;
    int          err_count   = 0;

    most_saturated_pixel_picker_top i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // clock
    always #10 aclk = ~aclk;

    // truncating Q30 product
    function automatic longint unsigned q30_mul(input longint unsigned x,
                                                input longint unsigned y);
        return (x * y) >> 30;
    endfunction

    // sRGB code to linear Q1.15: linear segment for low codes, else t^2.4 via a
    // search for the fifth root of t squared
    function automatic logic [15:0] srgb_to_lin(input int unsigned code);
        longint unsigned c;
        longint unsigned acc;
        longint unsigned t;
        longint unsigned t2;
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        longint unsigned p2;
        longint unsigned p4;
        c = code;
        if (c <= 64'd10) begin
            acc = (c * 64'd25 * (64'd1 << 30)) / 64'd82365;
        end else begin
            t  = ((64'd1000 * c + 64'd14025) << 30) / 64'd269025;
            t2 = q30_mul(t, t);
            lo = 64'd0;
            hi = 64'd1 << 30;
            while (lo < hi) begin
                mid = (lo + hi + 64'd1) >> 1;
                p2  = q30_mul(mid, mid);
                p4  = q30_mul(p2, p2);
                if (q30_mul(p4, mid) <= t2)
                    lo = mid;
                else
                    hi = mid - 64'd1;
            end
            acc = q30_mul(t2, lo);
        end
        return 16'((acc + (64'd1 << 14)) >> 15);
    endfunction

    // judge one accepted pixel; on the closing pixel queue the chosen colour
    task automatic pick_colour(input pixel_t px);
        logic [15:0] lr;
        logic [15:0] lg;
        logic [15:0] lb;
        logic [15:0] hi_ch;
        logic [15:0] lo_ch;
        logic [15:0] spread;
        logic [15:0] peak;
        colour_t     res;
        if (px.alpha != 8'd0) begin
            lr = lin_lut[px.red];
            lg = lin_lut[px.green];
            lb = lin_lut[px.blue];
            hi_ch = lr;
            lo_ch = lr;
            if (lg > hi_ch) hi_ch = lg;
            if (lb > hi_ch) hi_ch = lb;
            if (lg < lo_ch) lo_ch = lg;
            if (lb < lo_ch) lo_ch = lb;
            if (!(hi_ch < dark_thr || lo_ch > bright_thr)) begin
                spread = hi_ch - lo_ch;
                // black pixel counts with a peak of one
                peak = (hi_ch == 16'd0) ? 16'd1 : hi_ch;
                if (!have_best ||
                    32'(spread) * 32'(best_peak) > 32'(best_spread) * 32'(peak)) begin
                    best_red    = lr;
                    best_green  = lg;
                    best_blue   = lb;
                    best_alpha  = 16'((32'(px.alpha) * 32'd65536 + 32'd255) / 32'd510);
                    best_spread = spread;
                    best_peak   = peak;
                    have_best   = 1'b1;
                end
            end
        end
        if (px.last) begin
            res.red   = best_red;
            res.green = best_green;
            res.blue  = best_blue;
            res.alpha = best_alpha;
            res.found = have_best;
            colour_due.push_back(res);
            best_red    = ONE;
            best_green  = ONE;
            best_blue   = ONE;
            best_alpha  = ONE;
            best_spread = '0;
            best_peak   = '0;
            have_best   = 1'b0;
        end
    endtask

    // one line per mismatch, output capped but every one counted
    task automatic report_mismatch(input string what, input int got, input int want);
        if (err_count < 100)
            $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        err_count++;
    endtask

    // byte biased towards the extremes
    function automatic logic [7:0] rand_byte();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            return 8'd0;
        else if (sel == 1)
            return 8'd255;
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic push_px(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                           input logic [7:0] a, input logic last);
        pixel_t px;
        px.red   = r;
        px.green = g;
        px.blue  = b;
        px.alpha = a;
        px.last  = last;
        pixel_queue.push_back(px);
    endtask

    // wait until every pixel is taken and every result word has come back
    task automatic wait_drained();
        while (pixel_queue.size() != 0 || s_tvalid || colour_due.size() != 0)
            @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    // one register write on the configuration channel
    task automatic write_reg(input cfg_reg_t idx, input logic [15:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_DARK_THR)
            dark_thr = val;
        else
            bright_thr = val;
    endtask

    // pixel driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                pick_colour(offered_px);
                accepted_px++;
            end
            if (!s_tvalid || s_tready) begin
                if (pixel_queue.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
                    offered_px = pixel_queue.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {offered_px.alpha, offered_px.blue,
                                 offered_px.green, offered_px.red};
                    s_tlast  <= offered_px.last;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result receiver and checker
    always @(posedge aclk) begin
        colour_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= !hold_rx && ($urandom_range(0, 99) >= rx_idle_pct);
            if (m_tvalid && m_tready) begin
                if (colour_due.size() == 0) begin
                    report_mismatch("unexpected result word", int'(m_tdata[15:0]), -1);
                end else begin
                    want = colour_due.pop_front();
                    if (m_tdata[15:0] !== want.red)
                        report_mismatch("red_linear", int'(m_tdata[15:0]), int'(want.red));
                    if (m_tdata[31:16] !== want.green)
                        report_mismatch("green_linear", int'(m_tdata[31:16]),
                                        int'(want.green));
                    if (m_tdata[47:32] !== want.blue)
                        report_mismatch("blue_linear", int'(m_tdata[47:32]), int'(want.blue));
                    if (m_tdata[63:48] !== want.alpha)
                        report_mismatch("alpha_linear", int'(m_tdata[63:48]),
                                        int'(want.alpha));
                    if (m_tuser[0] !== want.found)
                        report_mismatch("found_colour", int'(m_tuser[0]), int'(want.found));
                end
            end
        end
    end

    // long receiver stall so the block backs up and stalls its input
    initial begin
        while (accepted_px < 250) @(posedge aclk);
        hold_rx <= 1'b1;
        repeat (300) @(posedge aclk);
        hold_rx <= 1'b0;
    end

    // run limit
    initial begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

    // stimulus
    initial begin
        int p;
        int got;
        int len;
        int k;

        for (int c = 0; c < 256; c++)
            lin_lut[c] = srgb_to_lin(c);

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // directed images under reset thresholds
        tx_idle_pct <= 28;
        rx_idle_pct <= 82;
        push_px(8'd0, 8'd0, 8'd0, 8'd0, 1'b1);          // transparent only, white
        push_px(8'd255, 8'd255, 8'd255, 8'd255, 1'b1);  // too bright
        push_px(8'd0, 8'd0, 8'd0, 8'd255, 1'b1);        // too dark
        push_px(8'd200, 8'd100, 8'd50, 8'd255, 1'b0);   // first qualifier
        push_px(8'd255, 8'd0, 8'd0, 8'd1, 1'b0);        // full saturation wins
        push_px(8'd0, 8'd255, 8'd0, 8'd255, 1'b0);      // tie keeps the earlier pixel
        push_px(8'd0, 8'd0, 8'd255, 8'd128, 1'b0);
        push_px(8'd128, 8'd128, 8'd128, 8'd0, 1'b0);    // transparent
        push_px(8'd255, 8'd0, 8'd255, 8'd255, 1'b1);
        push_px(8'd255, 8'd128, 8'd0, 8'd255, 1'b0);
        push_px(8'd128, 8'd128, 8'd128, 8'd255, 1'b1);
        push_px(8'd10, 8'd11, 8'd12, 8'd255, 1'b0);     // edge of the linear segment
        push_px(8'd11, 8'd10, 8'd255, 8'd255, 1'b1);
        push_px(8'd255, 8'd254, 8'd1, 8'd170, 1'b0);
        push_px(8'd1, 8'd254, 8'd255, 8'd85, 1'b1);
        wait_drained();

        for (p = 0; p < 6; p++) begin
            // threshold setting for this phase
            case (p)
                0: begin
                    write_reg(REG_DARK_THR, 16'd0);
                    write_reg(REG_BRIGHT_THR, ONE);
                end
                1: begin
                    write_reg(REG_DARK_THR, ONE);
                    write_reg(REG_BRIGHT_THR, 16'd0);
                end
                3: begin
                    write_reg(REG_DARK_THR, DARK_RST);
                    write_reg(REG_BRIGHT_THR, BRIGHT_RST);
                end
                5: begin
                    write_reg(REG_DARK_THR, ONE);
                    write_reg(REG_BRIGHT_THR, ONE);
                end
                default: begin
                    write_reg(REG_DARK_THR, 16'($urandom_range(0, 32768)));
                    write_reg(REG_BRIGHT_THR, 16'($urandom_range(0, 32768)));
                end
            endcase
            case (p / 2)
                0: begin
                    tx_idle_pct <= 28;
                    rx_idle_pct <= 82;
                end
                1: begin
                    tx_idle_pct <= 82;
                    rx_idle_pct <= 28;
                end
                default: begin
                    tx_idle_pct <= 0;
                    rx_idle_pct <= 0;
                end
            endcase

            // black pixels with no dark threshold
            if (p == 0) begin
                push_px(8'd0, 8'd0, 8'd0, 8'd255, 1'b0);
                push_px(8'd0, 8'd0, 8'd0, 8'd255, 1'b0);
                push_px(8'd50, 8'd50, 8'd50, 8'd255, 1'b0);
                push_px(8'd0, 8'd0, 8'd1, 8'd255, 1'b1);
                push_px(8'd0, 8'd0, 8'd0, 8'd7, 1'b1);
            end

            // random images, mostly short
            got = 0;
            while (got < 150) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                                  : $urandom_range(1, 12);
                for (k = 0; k < len; k++)
                    push_px(rand_byte(), rand_byte(), rand_byte(),
                            ($urandom_range(0, 99) < 15) ? 8'd0 : rand_byte(),
                            k == len - 1);
                got += len;
                // sender waits for every result once in mid phase
                if (p == 3 && got >= 80 && got - len < 80)
                    wait_drained();
            end
            wait_drained();
        end

        repeat (20) @(posedge aclk);
        if (err_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
